[sv/ppu_pkg.sv]
// Shared constants and types for the perspective point projection unit.
package ppu_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_CAMERA_X        = 3'd0;
  localparam logic [2:0] REG_CAMERA_Y        = 3'd1;
  localparam logic [2:0] REG_CAMERA_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_YAW_COS_SIN     = 3'd3;
  localparam logic [2:0] REG_PITCH_COS_SIN   = 3'd4;
  localparam logic [2:0] REG_ROLL_COS_SIN    = 3'd5;
  localparam logic [2:0] REG_VIEW_DISTANCE   = 3'd6;
  localparam logic [2:0] REG_INTERSECTION_XY = 3'd7;

  localparam int CfgIdxW = 3;

  // Reset values of the registers
  localparam logic [31:0] RST_COS_SIN  = 32'h4000_0000;
  localparam logic [31:0] RST_DISTANCE = 32'h0100_0000;

  // Divider geometry: depth magnitude, quotient bits, dividend bits
  localparam int ZW       = 54;
  localparam int QW       = 62;
  localparam int NW       = 90;
  localparam int TOPW     = NW - QW;
  localparam int NUM_LANE = 3;

  // Divider lanes
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_S = 2;

  // Pipeline depth: front end, divider init plus steps, two finishing stages
  localparam int FRONT_STAGES = 10;
  localparam int BACK_STAGES  = 2;
  localparam int NUM_STAGES   = FRONT_STAGES + 1 + QW + BACK_STAGES;

  // One divider lane: partial remainder and dividend bits turning into quotient bits
  typedef struct packed {
    logic [ZW-1:0] rem;
    logic [QW-1:0] low;
  } div_lane_t;

  // One divider stage with the item's side information
  typedef struct packed {
    logic          zero;
    logic          zpos;
    logic [1:0]    neg;
    logic [1:0]    big;
    logic [ZW-1:0] zmag;
    div_lane_t [NUM_LANE-1:0] lane;
  } div_stage_t;

endpackage

[sv/ppu_channels.sv]
// Channel interfaces: point input, result output and configuration writes.
interface ppu_point_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] world_x;
  logic signed [23:0] world_y;
  logic signed [31:0] point_height;

  modport source (output valid, world_x, world_y, point_height, input ready);
  modport sink (input valid, world_x, world_y, point_height, output ready);
endinterface

interface ppu_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic               screen_x_valid;
  logic signed [31:0] screen_y;
  logic               screen_y_valid;
  logic signed [31:0] scale_factor;
  logic               scale_valid;

  modport source (output valid, screen_x, screen_x_valid, screen_y, screen_y_valid,
                  scale_factor, scale_valid, input ready);
  modport sink (input valid, screen_x, screen_x_valid, screen_y, screen_y_valid,
                scale_factor, scale_valid, output ready);
endinterface

interface ppu_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ppu_pkg::CfgIdxW-1:0]  index;
  logic [31:0]                  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/perspective_point_projection_unit.sv]
// Top level: pipelined perspective projection of world points to screen coordinates.
//
// Channels: points (sink) takes world_x, world_y, point_height; results (source)
// gives screen_x/y with valid flags and the Q16.16 scale; cfg (sink) writes the
// eight registers by index and is always ready. Write cfg only while the pipe is
// empty.
// Throughput: one point per cycle while the output is not held. The pipe depth from the
// input transfer to the result showing on the output register is set by the 62-step
// restoring dividers (one quotient bit per stage, three lanes side by side for
// screen x, screen y and scale), plus ten front-end stages for the subtract,
// rotate and multiply steps, one divider setup stage and two finishing stages.
// The whole pipe advances together: when the output register holds a result
// that is not taken, every stage holds and points.ready drops, so nothing is
// lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears all valid bits and loads the registers with their defaults
// (camera at origin, zero angles, view distance 256.0, no offset).
module perspective_point_projection_unit (
  input  logic      clk,
  input  logic      rst,
  ppu_point_if.sink    points,
  ppu_result_if.source results,
  ppu_cfg_if.sink      cfg
);

  // Configuration registers
  logic signed [23:0] camera_x;
  logic signed [23:0] camera_y;
  logic signed [31:0] camera_height;
  logic [31:0]        yaw_cs;
  logic [31:0]        pitch_cs;
  logic [31:0]        roll_cs;
  logic [31:0]        view_distance;
  logic [31:0]        intersection_xy;

  assign cfg.ready = 1'b1;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x        <= '0;
      camera_y        <= '0;
      camera_height   <= '0;
      yaw_cs          <= ppu_pkg::RST_COS_SIN;
      pitch_cs        <= ppu_pkg::RST_COS_SIN;
      roll_cs         <= ppu_pkg::RST_COS_SIN;
      view_distance   <= ppu_pkg::RST_DISTANCE;
      intersection_xy <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ppu_pkg::REG_CAMERA_X:        camera_x        <= cfg.data[23:0];
        ppu_pkg::REG_CAMERA_Y:        camera_y        <= cfg.data[23:0];
        ppu_pkg::REG_CAMERA_HEIGHT:   camera_height   <= cfg.data;
        ppu_pkg::REG_YAW_COS_SIN:     yaw_cs          <= cfg.data;
        ppu_pkg::REG_PITCH_COS_SIN:   pitch_cs        <= cfg.data;
        ppu_pkg::REG_ROLL_COS_SIN:    roll_cs         <= cfg.data;
        ppu_pkg::REG_VIEW_DISTANCE:   view_distance   <= cfg.data;
        ppu_pkg::REG_INTERSECTION_XY: intersection_xy <= cfg.data;
        default: ;
      endcase
    end
  end

  logic signed [15:0] cy, sy, cp, sp, cr, sr;
  logic signed [15:0] off_x, off_y;
  assign cy    = yaw_cs[31:16];
  assign sy    = yaw_cs[15:0];
  assign cp    = pitch_cs[31:16];
  assign sp    = pitch_cs[15:0];
  assign cr    = roll_cs[31:16];
  assign sr    = roll_cs[15:0];
  assign off_x = intersection_xy[31:16];
  assign off_y = intersection_xy[15:0];

  // Pipeline advance and valid bits
  logic                           en;
  logic [ppu_pkg::NUM_STAGES-1:0] vld;

  assign en           = !vld[ppu_pkg::NUM_STAGES-1] || results.ready;
  assign points.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ppu_pkg::NUM_STAGES-2:0], points.valid};
    end
  end

  // Front-end payload registers
  logic signed [24:0] s1_dx, s1_dz;
  logic signed [32:0] s1_dh, s2_dh, s3_dh;
  logic signed [40:0] s2_cyx, s2_syz, s2_cyz, s2_syx;
  logic signed [35:0] s3_x1, s3_z1, s4_x1, s5_x1;
  logic signed [51:0] s4_spz, s4_cpz;
  logic signed [48:0] s4_cph, s4_sph;
  logic signed [38:0] s5_yr;
  logic signed [53:0] s5_zq;
  logic signed [51:0] s6_crx, s6_srx;
  logic signed [54:0] s6_sry, s6_cry;
  logic               s6_zero, s6_zpos, s7_zero, s7_zpos, s8_zero, s8_zpos;
  logic               s9_zero, s9_zpos, s10_zero, s10_zpos;
  logic [ppu_pkg::ZW-1:0] s6_zmag, s7_zmag, s8_zmag, s9_zmag, s10_zmag;
  logic signed [42:0] s7_u, s7_v;
  logic [42:0]        s8_umag, s8_vmag;
  logic [1:0]         s8_neg, s9_neg, s10_neg;
  logic [53:0]        s9_ul, s9_vl;
  logic [52:0]        s9_uh, s9_vh;
  logic [ppu_pkg::NW-1:0] s10_nu, s10_nv, s10_ns;

  // Combinational sums of the front end
  logic signed [41:0] sum_x1, sum_z1;
  logic signed [52:0] sum_yr;
  logic signed [56:0] sum_u, sum_v;
  logic [75:0]        sum_um, sum_vm;

  assign sum_x1 = 42'(s2_cyx) + 42'(s2_syz) + 42'sd32;
  assign sum_z1 = 42'(s2_cyz) - 42'(s2_syx) + 42'sd32;
  assign sum_yr = 53'(s4_spz) + 53'(s4_cph) + 53'sd8192;
  assign sum_u  = 57'(s6_crx) - 57'(s6_sry) + 57'sd8192;
  assign sum_v  = -57'(s6_srx) - 57'(s6_cry) + 57'sd8192;
  assign sum_um = (76'(s9_uh) << 22) + 76'(s9_ul);
  assign sum_vm = (76'(s9_vh) << 22) + 76'(s9_vl);

  // Subtract camera, rotate by yaw, pitch and roll, scale the numerators by distance
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx    <= 25'(points.world_x) - 25'(camera_x);
      s1_dz    <= 25'(points.world_y) - 25'(camera_y);
      s1_dh    <= 33'(points.point_height) - 33'(camera_height);

      s2_cyx   <= 41'(cy) * 41'(s1_dx);
      s2_syz   <= 41'(sy) * 41'(s1_dz);
      s2_cyz   <= 41'(cy) * 41'(s1_dz);
      s2_syx   <= 41'(sy) * 41'(s1_dx);
      s2_dh    <= s1_dh;

      s3_x1    <= sum_x1[41:6];
      s3_z1    <= sum_z1[41:6];
      s3_dh    <= s2_dh;

      s4_spz   <= 52'(sp) * 52'(s3_z1);
      s4_cpz   <= 52'(cp) * 52'(s3_z1);
      s4_cph   <= 49'(cp) * 49'(s3_dh);
      s4_sph   <= 49'(sp) * 49'(s3_dh);
      s4_x1    <= s3_x1;

      s5_yr    <= sum_yr[52:14];
      s5_zq    <= 54'(s4_cpz) - 54'(s4_sph);
      s5_x1    <= s4_x1;

      s6_crx   <= 52'(cr) * 52'(s5_x1);
      s6_srx   <= 52'(sr) * 52'(s5_x1);
      s6_sry   <= 55'(sr) * 55'(s5_yr);
      s6_cry   <= 55'(cr) * 55'(s5_yr);
      s6_zero  <= (s5_zq == '0);
      s6_zpos  <= !s5_zq[53] && (s5_zq != '0);
      s6_zmag  <= s5_zq[53] ? ppu_pkg::ZW'(-s5_zq) : ppu_pkg::ZW'(s5_zq);

      s7_u     <= sum_u[56:14];
      s7_v     <= sum_v[56:14];
      s7_zero  <= s6_zero;
      s7_zpos  <= s6_zpos;
      s7_zmag  <= s6_zmag;

      s8_umag  <= s7_u[42] ? 43'(-s7_u) : 43'(s7_u);
      s8_vmag  <= s7_v[42] ? 43'(-s7_v) : 43'(s7_v);
      s8_neg   <= {s7_zpos ^ s7_v[42], s7_zpos ^ s7_u[42]};
      s8_zero  <= s7_zero;
      s8_zpos  <= s7_zpos;
      s8_zmag  <= s7_zmag;

      s9_ul    <= 54'(s8_umag[21:0]) * 54'(view_distance);
      s9_uh    <= 53'(s8_umag[42:22]) * 53'(view_distance);
      s9_vl    <= 54'(s8_vmag[21:0]) * 54'(view_distance);
      s9_vh    <= 53'(s8_vmag[42:22]) * 53'(view_distance);
      s9_neg   <= s8_neg;
      s9_zero  <= s8_zero;
      s9_zpos  <= s8_zpos;
      s9_zmag  <= s8_zmag;

      s10_nu   <= {sum_um[74:0], 14'b0, 1'b0} >> 1;
      s10_nv   <= {sum_vm[74:0], 14'b0, 1'b0} >> 1;
      s10_ns   <= ppu_pkg::NW'({view_distance, 22'b0});
      s10_neg  <= s9_neg;
      s10_zero <= s9_zero;
      s10_zpos <= s9_zpos;
      s10_zmag <= s9_zmag;
    end
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits
  function automatic ppu_pkg::div_lane_t div_step(ppu_pkg::div_lane_t l,
                                                  logic [ppu_pkg::ZW-1:0] d);
    logic [ppu_pkg::ZW:0] t;
    logic                 ge;
    ppu_pkg::div_lane_t   r;
    t     = {l.rem, l.low[ppu_pkg::QW-1]};
    ge    = (t >= {1'b0, d});
    r.rem = ge ? ppu_pkg::ZW'(t - {1'b0, d}) : t[ppu_pkg::ZW-1:0];
    r.low = {l.low[ppu_pkg::QW-2:0], ge};
    return r;
  endfunction

  // Divider pipeline: setup stage, then one quotient bit per stage
  ppu_pkg::div_stage_t ds [0:ppu_pkg::QW];
  logic [ppu_pkg::NW-1:0] num [ppu_pkg::NUM_LANE];

  assign num[ppu_pkg::LANE_X] = s10_nu;
  assign num[ppu_pkg::LANE_Y] = s10_nv;
  assign num[ppu_pkg::LANE_S] = s10_ns;

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0].zero <= s10_zero;
      ds[0].zpos <= s10_zpos;
      ds[0].neg  <= s10_neg;
      ds[0].zmag <= s10_zmag;
      ds[0].big  <= {ppu_pkg::ZW'(s10_nv[ppu_pkg::NW-1:ppu_pkg::QW]) >= s10_zmag,
                     ppu_pkg::ZW'(s10_nu[ppu_pkg::NW-1:ppu_pkg::QW]) >= s10_zmag};
      for (int l = 0; l < ppu_pkg::NUM_LANE; l++) begin
        ds[0].lane[l].rem <= ppu_pkg::ZW'(num[l][ppu_pkg::NW-1:ppu_pkg::QW]);
        ds[0].lane[l].low <= num[l][ppu_pkg::QW-1:0];
      end
    end
  end

  for (genvar k = 1; k <= ppu_pkg::QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        ds[k].zero <= ds[k-1].zero;
        ds[k].zpos <= ds[k-1].zpos;
        ds[k].neg  <= ds[k-1].neg;
        ds[k].big  <= ds[k-1].big;
        ds[k].zmag <= ds[k-1].zmag;
        for (int l = 0; l < ppu_pkg::NUM_LANE; l++) begin
          ds[k].lane[l] <= div_step(ds[k-1].lane[l], ds[k-1].zmag);
        end
      end
    end
  end

  // Finishing stage one: apply sign and offset, saturate the scale
  ppu_pkg::div_stage_t  dq;
  logic signed [63:0]   qx, qy, tx, ty;
  logic [ppu_pkg::QW-1:0] qs;
  logic [31:0]          scale_c;
  logic signed [63:0]   f_tx, f_ty;
  logic [1:0]           f_big;
  logic                 f_zero;
  logic [31:0]          f_scale;

  assign dq = ds[ppu_pkg::QW];
  assign qx = $signed({2'b00, dq.lane[ppu_pkg::LANE_X].low});
  assign qy = $signed({2'b00, dq.lane[ppu_pkg::LANE_Y].low});
  assign qs = dq.lane[ppu_pkg::LANE_S].low;
  assign tx = (dq.neg[0] ? -qx : qx) + $signed({{32{off_x[15]}}, off_x, 16'h0});
  assign ty = (dq.neg[1] ? -qy : qy) + $signed({{32{off_y[15]}}, off_y, 16'h0});

  always_comb begin
    if (dq.zpos) begin
      scale_c = (qs > ppu_pkg::QW'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(-qs);
    end else begin
      scale_c = (qs > ppu_pkg::QW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qs[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_tx    <= tx;
      f_ty    <= ty;
      f_big   <= dq.big;
      f_zero  <= dq.zero;
      f_scale <= scale_c;
    end
  end

  // Finishing stage two: truncate toward zero to whole pixels, range check
  logic signed [63:0] rx, ry;
  logic [47:0]        px, py;
  logic               fit_x, fit_y, ok_x, ok_y;

  assign rx    = f_tx + (f_tx[63] ? 64'sd65535 : 64'sd0);
  assign ry    = f_ty + (f_ty[63] ? 64'sd65535 : 64'sd0);
  assign px    = rx[63:16];
  assign py    = ry[63:16];
  assign fit_x = (px[47:31] == '0) || (px[47:31] == '1);
  assign fit_y = (py[47:31] == '0) || (py[47:31] == '1);
  assign ok_x  = !f_zero && !f_big[0] && fit_x;
  assign ok_y  = !f_zero && !f_big[1] && fit_y;

  logic [31:0] o_x, o_y, o_scale;
  logic        o_x_ok, o_y_ok, o_s_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      o_x     <= ok_x ? px[31:0] : '0;
      o_y     <= ok_y ? py[31:0] : '0;
      o_x_ok  <= ok_x;
      o_y_ok  <= ok_y;
      o_scale <= f_zero ? '0 : f_scale;
      o_s_ok  <= !f_zero;
    end
  end

  // Drive the result channel from the output register
  assign results.valid          = vld[ppu_pkg::NUM_STAGES-1];
  assign results.screen_x       = o_x;
  assign results.screen_x_valid = o_x_ok;
  assign results.screen_y       = o_y;
  assign results.screen_y_valid = o_y_ok;
  assign results.scale_factor   = o_scale;
  assign results.scale_valid    = o_s_ok;

endmodule
